[rtl/laiir_pkg.sv]
// ----------------------------------------------------------------------------
// laiir_pkg
// Shared widths, register indexes, reset coefficients and the coefficient
// bundle for the look-ahead first-order IIR filter.
// ----------------------------------------------------------------------------
package laiir_pkg;

	// sample and coefficient format, Q1.FRAC_W
	localparam int DATA_W = 11;
	localparam int FRAC_W = DATA_W - 1;
	// derived coefficients need one more bit than the programmed ones
	localparam int COEF_W = DATA_W + 1;
	// width of the numerator and feedback terms
	localparam int ACC_W  = DATA_W + 3;
	// raw product widths
	localparam int PROD_W  = 2 * DATA_W;
	localparam int WPROD_W = DATA_W + COEF_W;
	// configuration index width
	localparam int IDX_W  = 2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_B0 = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_B1 = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_A1 = IDX_W'(2);

	// coefficients after reset
	localparam int B0_RESET = 430;
	localparam int B1_RESET = 430;
	localparam int A1_RESET = -163;
	localparam int C0_RESET = B1_RESET - ((A1_RESET * B0_RESET) >>> FRAC_W);
	localparam int C1_RESET = (A1_RESET * B1_RESET) >>> FRAC_W;
	localparam int C2_RESET = (A1_RESET * A1_RESET) >>> FRAC_W;

	// coefficients as the datapath uses them
	typedef struct packed {
		logic signed [DATA_W-1:0] b0;
		logic signed [COEF_W-1:0] c0;
		logic signed [COEF_W-1:0] c1;
		logic signed [COEF_W-1:0] c2;
	} laiir_coef_t;

endpackage

[rtl/lookahead_first_order_iir_unit.sv]
// ----------------------------------------------------------------------------
// lookahead_first_order_iir_unit
// First-order IIR filter in look-ahead pipelined form with saturated output.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready, sample_in): one signed sample per beat.
//   Output channel (out_valid/out_ready, sample_out): one filtered sample per
//   input beat, in order.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 b0, 1 b1, 2 a1); index 3 is ignored. Write only while the filter is
//   idle; derived look-ahead coefficients are formed in the same cycle.
//   Output: each accepted beat loads the filter output y into sample_out;
//   a sample's b0 term passes b0d0_q, b0d1_q and sum_q before it reaches y.
//   Throughput: one sample per cycle while out_ready holds high; the output
//   register is the only stage between the channels, so in_ready stays high
//   while the receiver takes each result.
//   Stall: while out_ready is low with a result waiting, in_ready drops and
//   the result holds; no beat is lost.
//   Reset: arst_n clears filter state and the output valid flag and loads the
//   default coefficients (b0 = b1 = 430, a1 = -163).
// ----------------------------------------------------------------------------
module lookahead_first_order_iir_unit
	import laiir_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] sample_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] sample_out,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [DATA_W-1:0]        cfg_data
);

	laiir_coef_t              coef;
	logic                     in_beat;
	logic signed [DATA_W-1:0] y;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] sample_out_q;

	// coefficient registers
	laiir_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	// filter state
	laiir_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (in_beat),
		.x      (sample_in),
		.coef   (coef),
		.y      (y)
	);

	// handshake
	assign in_ready = !out_valid_q || out_ready;
	assign in_beat  = in_valid && in_ready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			sample_out_q <= y;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

`ifndef SYNTHESIS
	// every accepted beat leaves a result waiting
	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted beat produced no result");

	// a result leaves only when taken
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without being taken");

	// a waiting result is replaced only by a new beat
	a_replace: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !in_valid |=> !out_valid)
		else $error("result repeated");
`endif

endmodule

[rtl/laiir_coef.sv]
// ----------------------------------------------------------------------------
// laiir_coef
// Coefficient registers with look-ahead coefficients derived at write time,
// so the sample path never chains two multiplications.
// ----------------------------------------------------------------------------
module laiir_coef
	import laiir_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	output laiir_coef_t       coef
);

	logic signed [DATA_W-1:0] b0_q, b1_q, a1_q;
	logic signed [COEF_W-1:0] c0_q, c1_q, c2_q;
	logic signed [DATA_W-1:0] nb0, nb1, na1;
	logic signed [PROD_W-1:0] p_ab0, p_ab1, p_aa;
	logic signed [COEF_W-1:0] c0_next, c1_next, c2_next;

	// programmed values as they stand after this write
	always_comb begin
		nb0 = b0_q;
		nb1 = b1_q;
		na1 = a1_q;
		case (cfg_index)
			REG_B0: nb0 = cfg_data;
			REG_B1: nb1 = cfg_data;
			REG_A1: na1 = cfg_data;
			default: ;
		endcase
	end

	// derived look-ahead coefficients
	assign p_ab0   = na1 * nb0;
	assign p_ab1   = na1 * nb1;
	assign p_aa    = na1 * na1;
	assign c0_next = COEF_W'(nb1) - COEF_W'(p_ab0 >>> FRAC_W);
	assign c1_next = COEF_W'(p_ab1 >>> FRAC_W);
	assign c2_next = COEF_W'(p_aa >>> FRAC_W);

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= DATA_W'(B0_RESET);
			b1_q <= DATA_W'(B1_RESET);
			a1_q <= DATA_W'(A1_RESET);
			c0_q <= COEF_W'(C0_RESET);
			c1_q <= COEF_W'(C1_RESET);
			c2_q <= COEF_W'(C2_RESET);
		end else if (cfg_we) begin
			b0_q <= nb0;
			b1_q <= nb1;
			a1_q <= na1;
			c0_q <= c0_next;
			c1_q <= c1_next;
			c2_q <= c2_next;
		end
	end

	assign coef.b0 = b0_q;
	assign coef.c0 = c0_q;
	assign coef.c1 = c1_q;
	assign coef.c2 = c2_q;

endmodule

[rtl/laiir_datapath.sv]
// ----------------------------------------------------------------------------
// laiir_datapath
// Filter state and delay chain; advances by one sample on each accepted beat
// and presents the saturated output for that beat.
// ----------------------------------------------------------------------------
module laiir_datapath
	import laiir_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic signed [DATA_W-1:0] x,
	input  laiir_coef_t              coef,
	output logic signed [DATA_W-1:0] y
);

	localparam logic signed [DATA_W:0] Y_MAX = (DATA_W+1)'((1 << (DATA_W - 1)) - 1);
	localparam logic signed [DATA_W:0] Y_MIN = -(DATA_W+1)'(1 << (DATA_W - 1));

	logic signed [DATA_W-1:0]  p0_q, p1_q, last_q;
	logic signed [ACC_W-1:0]   b0d0_q, b0d1_q, c0p_q, c1p_q, diff_q, sum_q, fb_q;
	logic signed [PROD_W-1:0]  b0_prod;
	logic signed [WPROD_W-1:0] c0_prod, c1_prod, fb_prod;
	logic signed [ACC_W:0]     y_wide;

	// products for this beat, one multiplier each
	assign b0_prod = coef.b0 * x;
	assign c0_prod = coef.c0 * p0_q;
	assign c1_prod = coef.c1 * p1_q;
	assign fb_prod = coef.c2 * last_q;

	// output from the delayed feedback and numerator terms, saturated
	assign y_wide = (ACC_W+1)'(fb_q) + (ACC_W+1)'(sum_q);
	always_comb begin
		if (y_wide > (ACC_W+1)'(Y_MAX))
			y = DATA_W'(Y_MAX);
		else if (y_wide < (ACC_W+1)'(Y_MIN))
			y = DATA_W'(Y_MIN);
		else
			y = DATA_W'(y_wide);
	end

	// state and delay chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0_q   <= '0;
			p1_q   <= '0;
			last_q <= '0;
			b0d0_q <= '0;
			b0d1_q <= '0;
			c0p_q  <= '0;
			c1p_q  <= '0;
			diff_q <= '0;
			sum_q  <= '0;
			fb_q   <= '0;
		end else if (step) begin
			p0_q   <= x;
			p1_q   <= p0_q;
			last_q <= y;
			b0d0_q <= ACC_W'(b0_prod >>> FRAC_W);
			b0d1_q <= b0d0_q;
			c0p_q  <= ACC_W'(c0_prod >>> FRAC_W);
			c1p_q  <= ACC_W'(c1_prod >>> FRAC_W);
			diff_q <= c0p_q - c1p_q;
			sum_q  <= b0d1_q + diff_q;
			fb_q   <= ACC_W'(fb_prod >>> FRAC_W);
		end
	end

`ifndef SYNTHESIS
	// state holds between beats
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(last_q) && $stable(p0_q) && $stable(sum_q))
		else $error("filter state moved without a beat");

	// input delay line shifts by one on each beat
	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> p1_q == $past(p0_q) && p0_q == $past(x))
		else $error("input delay line out of step");

	// fed-back output is the one just presented
	a_feedback: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> last_q == $past(y))
		else $error("feedback sample mismatch");
`endif

endmodule
